[design/msc_pkg.sv]
package msc_pkg;

  // Fixed-point and divider sizes
  localparam int DW        = 32;
  localparam int CFG_W     = 31;
  localparam int WIDE_W    = 50;
  localparam int DIV_W     = 49;
  localparam logic [5:0] DIV_STEPS = 6'd49;
  localparam logic [16:0] Q_ONE    = 17'd65536;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_TORQUE = 2'd0;
  localparam logic [1:0] REG_INER_GAIN  = 2'd1;
  localparam logic [1:0] REG_RES_DAMP   = 2'd2;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_ACC_CUR,
    OP_ACC_INE,
    OP_ERR,
    OP_FORCE,
    OP_TVAL,
    OP_ADD,
    OP_DIVQ_INIT,
    OP_DIVA_INIT,
    OP_DIV_STEP,
    OP_QSET,
    OP_CLAMP,
    OP_ACCEL,
    OP_TORQ,
    OP_OUT,
    OP_OUT_ZERO
  } dp_op_t;

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    M_SPIN,
    M_INER,
    M_ERR,
    M_GAIN,
    M_QF,
    M_DAMP_T,
    M_DAMP_PF,
    M_TORQ
  } msel_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] op_idx;
    logic       mul_en;
    msel_t      msel;
    logic [1:0] mul_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic target_zero;
    logic case_a;
    logic case_b;
  } dp_stat_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [DW-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = 50'sd2147483647;
    lo = -50'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end else begin
      return v[DW-1:0];
    end
  endfunction

endpackage

[design/motor_speed_torque_controller_core.sv]
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------------
// in       | in_valid / in_stall        | target_speed, axis_*, spin_*, inertia_*
// out      | out_valid / out_stall      | torque_x, torque_y, torque_z, drive_applied
// cfg      | cfg_we (no stall)          | cfg_index, cfg_data
//
// A zero target skips the arithmetic: its zero result is written once the
// output is free. Other items may add a steady-state term, or a progress
// term that runs its ratio division. The 49-step restoring divider does the
// divisions, and one shared 33x33 multiplier does every product. An item is
// accepted only while the sequencer is idle. A result held by out_stall
// blocks only the final write of the next item's result. rst is synchronous;
// it restores register reset values and clears prev speed, accel and force.
module motor_speed_torque_controller_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] target_speed,
  input  logic signed [31:0] axis_x,
  input  logic signed [31:0] axis_y,
  input  logic signed [31:0] axis_z,
  input  logic signed [31:0] spin_x,
  input  logic signed [31:0] spin_y,
  input  logic signed [31:0] spin_z,
  input  logic signed [31:0] inertia_x,
  input  logic signed [31:0] inertia_y,
  input  logic signed [31:0] inertia_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] torque_x,
  output logic signed [31:0] torque_y,
  output logic signed [31:0] torque_z,
  output logic               drive_applied
);
  import msc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  msc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  msc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .target_speed  (target_speed),
    .axis_x        (axis_x),
    .axis_y        (axis_y),
    .axis_z        (axis_z),
    .spin_x        (spin_x),
    .spin_y        (spin_y),
    .spin_z        (spin_z),
    .inertia_x     (inertia_x),
    .inertia_y     (inertia_y),
    .inertia_z     (inertia_z),
    .torque_x      (torque_x),
    .torque_y      (torque_y),
    .torque_z      (torque_z),
    .drive_applied (drive_applied)
  );

  // Capture only on an accepted item
  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD) |-> (in_valid && !in_stall))
    else $error("item captured without accept");

  // Never overwrite a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT || cmd.op == OP_OUT_ZERO) |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  // Busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while busy");

  // Heuristic branches are exclusive
  a_case_excl: assert property (@(posedge clk) disable iff (rst)
    !(stat.case_a && stat.case_b))
    else $error("both heuristic branches selected");

endmodule

[design/msc_datapath.sv]
module msc_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  msc_pkg::dp_cmd_t         cmd,
  output msc_pkg::dp_stat_t        stat,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [30:0]              cfg_data,
  input  logic signed [31:0]       target_speed,
  input  logic signed [31:0]       axis_x,
  input  logic signed [31:0]       axis_y,
  input  logic signed [31:0]       axis_z,
  input  logic signed [31:0]       spin_x,
  input  logic signed [31:0]       spin_y,
  input  logic signed [31:0]       spin_z,
  input  logic signed [31:0]       inertia_x,
  input  logic signed [31:0]       inertia_y,
  input  logic signed [31:0]       inertia_z,
  output logic signed [31:0]       torque_x,
  output logic signed [31:0]       torque_y,
  output logic signed [31:0]       torque_z,
  output logic                     drive_applied
);
  import msc_pkg::*;

  // Configuration
  logic [CFG_W-1:0] max_torque;
  logic [CFG_W-1:0] inertia_gain;
  logic [CFG_W-1:0] resistance_damping;

  // Captured item
  logic signed [DW-1:0] target;
  logic signed [DW-1:0] ax [3];
  logic signed [DW-1:0] sp [3];
  logic signed [DW-1:0] in3 [3];

  // Working values and controller state
  logic signed [WIDE_W-1:0] cur_acc;
  logic signed [WIDE_W-1:0] ine_acc;
  logic signed [DW-1:0]     cur;
  logic signed [DW-1:0]     ine;
  logic signed [DW-1:0]     err;
  logic signed [DW-1:0]     force_v;
  logic signed [47:0]       tval;
  logic [16:0]              q;
  logic signed [DW-1:0]     prev_speed;
  logic signed [DW-1:0]     prev_accel;
  logic signed [DW-1:0]     prev_force;
  logic signed [DW-1:0]     tq [3];

  // Multiplier
  logic signed [32:0]       ma;
  logic signed [32:0]       mb;
  logic signed [65:0]       prod;
  logic signed [WIDE_W-1:0] prod_sh;
  logic [65:0]              prod_mag;

  // Divider
  logic [DIV_W-1:0] dq;
  logic [31:0]      dv;
  logic [31:0]      rem;
  logic [32:0]      r2;
  logic [32:0]      r2_sub;
  logic             r2_ge;

  // Decision terms
  logic signed [32:0]       ds;
  logic [32:0]              ds_mag;
  logic [31:0]              pa_mag;
  logic [31:0]              force_mag;
  logic [37:0]              ds_x20;
  logic                     ds_pos;
  logic                     err_pos;
  logic                     pa_pos;
  logic signed [WIDE_W-1:0] err_wide;
  logic signed [DW-1:0]     cur_sat;
  logic signed [32:0]       force_ext;
  logic signed [32:0]       mt_ext;

  // Pick multiplier operands
  always_comb begin
    case (cmd.msel)
      M_SPIN: begin
        ma = 33'(sp[cmd.mul_idx]);
        mb = 33'(ax[cmd.mul_idx]);
      end
      M_INER: begin
        ma = 33'(in3[cmd.mul_idx]);
        mb = 33'(ax[cmd.mul_idx]);
      end
      M_ERR: begin
        ma = 33'(err);
        mb = 33'(ine);
      end
      M_GAIN: begin
        ma = 33'(force_v);
        mb = $signed({2'b00, inertia_gain});
      end
      M_QF: begin
        ma = 33'(prev_force);
        mb = $signed({16'd0, Q_ONE - q});
      end
      M_DAMP_T: begin
        ma = tval[32:0];
        mb = $signed({2'b00, resistance_damping});
      end
      M_DAMP_PF: begin
        ma = 33'(prev_force);
        mb = $signed({2'b00, resistance_damping});
      end
      M_TORQ: begin
        ma = 33'(ax[cmd.mul_idx]);
        mb = 33'(force_v);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= ma * mb;
    end
  end

  assign prod_sh  = prod[65:16];
  assign prod_mag = prod[65] ? 66'(-prod) : prod;

  // Divider step terms
  assign r2     = {rem, dq[DIV_W-1]};
  assign r2_sub = r2 - {1'b0, dv};
  assign r2_ge  = r2 >= {1'b0, dv};

  // Heuristic decision terms
  assign ds        = 33'(cur) - 33'(prev_speed);
  assign ds_mag    = ds[32] ? 33'(-ds) : ds;
  assign pa_mag    = prev_accel[31] ? 32'(-prev_accel) : prev_accel;
  assign force_mag = force_v[31] ? 32'(-force_v) : force_v;
  assign ds_x20    = {5'd0, ds_mag} * 38'd20;
  assign ds_pos    = !ds[32] && (ds != '0);
  assign err_pos   = !err[31] && (err != '0);
  assign pa_pos    = !prev_accel[31] && (prev_accel != '0);
  assign cur_sat   = sat32(cur_acc);
  assign err_wide  = WIDE_W'(target) - WIDE_W'(cur_sat);
  assign force_ext = 33'(force_v);
  assign mt_ext    = $signed({2'b00, max_torque});

  always_comb begin
    stat.target_zero = (target == '0);
    stat.case_a = (prev_accel != '0) && (ds != '0) && (err != '0) && (ds_pos == err_pos);
    stat.case_b = (prev_accel != '0) && !stat.case_a && (cur != '0) &&
                  (ds_x20 < {6'd0, pa_mag});
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_torque         <= '0;
      inertia_gain       <= 31'd65536;
      resistance_damping <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_TORQUE: max_torque         <= cfg_data;
        REG_INER_GAIN:  inertia_gain       <= cfg_data;
        REG_RES_DAMP:   resistance_damping <= cfg_data;
        default: ;
      endcase
    end
  end

  // Carried state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_speed    <= '0;
      prev_accel    <= '0;
      prev_force    <= '0;
      drive_applied <= 1'b0;
    end else begin
      case (cmd.op)
        OP_ACCEL: begin
          prev_speed <= cur;
          prev_force <= force_v;
          if (ine == '0) begin
            prev_accel <= '0;
          end else if (force_v[31]) begin
            prev_accel <= (dq >= 49'h80000000) ? 32'sh80000000 : 32'(-dq[31:0]);
          end else begin
            prev_accel <= (dq >= 49'h7fffffff) ? 32'sh7fffffff : dq[31:0];
          end
        end
        OP_OUT:      drive_applied <= 1'b1;
        OP_OUT_ZERO: drive_applied <= 1'b0;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        target  <= target_speed;
        ax[0]   <= axis_x;
        ax[1]   <= axis_y;
        ax[2]   <= axis_z;
        sp[0]   <= spin_x;
        sp[1]   <= spin_y;
        sp[2]   <= spin_z;
        in3[0]  <= inertia_x;
        in3[1]  <= inertia_y;
        in3[2]  <= inertia_z;
        cur_acc <= '0;
        ine_acc <= '0;
      end
      OP_ACC_CUR: cur_acc <= cur_acc + prod_sh;
      OP_ACC_INE: ine_acc <= ine_acc + $signed(prod_mag[65:16]);
      OP_ERR: begin
        cur <= cur_sat;
        ine <= sat32(ine_acc);
        err <= sat32(err_wide);
      end
      OP_FORCE: force_v <= sat32(prod_sh);
      OP_TVAL:  tval    <= prod_sh[47:0];
      OP_ADD:   force_v <= sat32(WIDE_W'(force_v) + WIDE_W'(tval));
      OP_DIVQ_INIT: begin
        dq  <= {ds_mag, 16'd0};
        dv  <= pa_mag;
        rem <= '0;
      end
      OP_DIVA_INIT: begin
        dq  <= {1'b0, force_mag, 16'd0};
        dv  <= ine;
        rem <= '0;
      end
      OP_DIV_STEP: begin
        rem <= r2_ge ? r2_sub[31:0] : r2[31:0];
        dq  <= {dq[DIV_W-2:0], r2_ge};
      end
      OP_QSET: begin
        if (ds_pos != pa_pos) begin
          q <= '0;
        end else if (ds_mag >= {1'b0, pa_mag}) begin
          q <= Q_ONE;
        end else begin
          q <= dq[16:0];
        end
      end
      OP_CLAMP: begin
        if (max_torque != '0) begin
          if (force_ext > mt_ext) begin
            force_v <= mt_ext[31:0];
          end else if (force_ext < -mt_ext) begin
            force_v <= 32'(-mt_ext);
          end
        end
      end
      OP_TORQ: tq[cmd.op_idx] <= sat32(prod_sh);
      OP_OUT: begin
        torque_x <= tq[0];
        torque_y <= tq[1];
        torque_z <= tq[2];
      end
      OP_OUT_ZERO: begin
        torque_x <= '0;
        torque_y <= '0;
        torque_z <= '0;
      end
      default: ;
    endcase
  end

endmodule

[design/msc_ctrl.sv]
module msc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  msc_pkg::dp_stat_t  stat,
  output msc_pkg::dp_cmd_t   cmd
);
  import msc_pkg::*;

  typedef enum logic [24:0] {
    S_IDLE  = 25'b1 << 0,
    S_CHK   = 25'b1 << 1,
    S_ZOUT  = 25'b1 << 2,
    S_DOT   = 25'b1 << 3,
    S_ERR   = 25'b1 << 4,
    S_F1    = 25'b1 << 5,
    S_F2    = 25'b1 << 6,
    S_G1    = 25'b1 << 7,
    S_G2    = 25'b1 << 8,
    S_HEUR  = 25'b1 << 9,
    S_QINIT = 25'b1 << 10,
    S_QDIV  = 25'b1 << 11,
    S_QSET  = 25'b1 << 12,
    S_A1    = 25'b1 << 13,
    S_A2    = 25'b1 << 14,
    S_A3    = 25'b1 << 15,
    S_A4    = 25'b1 << 16,
    S_B2    = 25'b1 << 17,
    S_ADD   = 25'b1 << 18,
    S_CLAMP = 25'b1 << 19,
    S_AINIT = 25'b1 << 20,
    S_ADIV  = 25'b1 << 21,
    S_ACCEL = 25'b1 << 22,
    S_TORQ  = 25'b1 << 23,
    S_OUT   = 25'b1 << 24
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [5:0] cnt;
  logic [5:0] cnt_next;
  logic       out_free;
  logic       out_set;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Sequence one item
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    out_set     = 1'b0;
    cmd.op      = OP_NOP;
    cmd.op_idx  = 2'd0;
    cmd.mul_en  = 1'b0;
    cmd.msel    = M_SPIN;
    cmd.mul_idx = 2'd0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        cnt_next   = '0;
        state_next = stat.target_zero ? S_ZOUT : S_DOT;
      end
      S_ZOUT: begin
        if (out_free) begin
          cmd.op     = OP_OUT_ZERO;
          out_set    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DOT: begin
        // Issue product k, accumulate product k-1
        cmd.mul_en  = (cnt < 6'd6);
        cmd.msel    = cnt[0] ? M_INER : M_SPIN;
        cmd.mul_idx = cnt[2:1];
        if (cnt != '0) begin
          cmd.op = cnt[0] ? OP_ACC_CUR : OP_ACC_INE;
        end
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd6) begin
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.op     = OP_ERR;
        state_next = S_F1;
      end
      S_F1: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = M_ERR;
        state_next = S_F2;
      end
      S_F2: begin
        cmd.op     = OP_FORCE;
        state_next = S_G1;
      end
      S_G1: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = M_GAIN;
        state_next = S_G2;
      end
      S_G2: begin
        cmd.op     = OP_FORCE;
        state_next = S_HEUR;
      end
      S_HEUR: begin
        if (stat.case_a) begin
          state_next = S_QINIT;
        end else if (stat.case_b) begin
          cmd.mul_en = 1'b1;
          cmd.msel   = M_DAMP_PF;
          state_next = S_B2;
        end else begin
          state_next = S_CLAMP;
        end
      end
      S_QINIT: begin
        cmd.op     = OP_DIVQ_INIT;
        cnt_next   = '0;
        state_next = S_QDIV;
      end
      S_QDIV: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == DIV_STEPS - 6'd1) begin
          state_next = S_QSET;
        end
      end
      S_QSET: begin
        cmd.op     = OP_QSET;
        state_next = S_A1;
      end
      S_A1: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = M_QF;
        state_next = S_A2;
      end
      S_A2: begin
        cmd.op     = OP_TVAL;
        state_next = S_A3;
      end
      S_A3: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = M_DAMP_T;
        state_next = S_A4;
      end
      S_A4: begin
        cmd.op     = OP_TVAL;
        state_next = S_ADD;
      end
      S_B2: begin
        cmd.op     = OP_TVAL;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.op     = OP_ADD;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.op     = OP_CLAMP;
        state_next = S_AINIT;
      end
      S_AINIT: begin
        cmd.op     = OP_DIVA_INIT;
        cnt_next   = '0;
        state_next = S_ADIV;
      end
      S_ADIV: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == DIV_STEPS - 6'd1) begin
          state_next = S_ACCEL;
        end
      end
      S_ACCEL: begin
        cmd.op     = OP_ACCEL;
        cnt_next   = '0;
        state_next = S_TORQ;
      end
      S_TORQ: begin
        // Issue torque product k, store product k-1
        cmd.mul_en  = (cnt < 6'd3);
        cmd.msel    = M_TORQ;
        cmd.mul_idx = cnt[1:0];
        if (cnt != '0) begin
          cmd.op     = OP_TORQ;
          cmd.op_idx = cnt[1:0] - 2'd1;
        end
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd3) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.op     = OP_OUT;
          out_set    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
